>>> design/swsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsr_pkg: shared types and constants
// Config register map, reset values and the result type for the
// single-wire sensor receiver.
// ----------------------------------------------------------------------------
package swsr_pkg;

    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 16;

    // register indexes
    localparam logic [CfgIdxW-1:0] REG_START_LOW    = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_RELEASE_WAIT = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_SAMPLE_DELAY = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_BYTES_FRAME  = 2'd3;

    // reset values
    localparam logic [15:0] START_LOW_RST    = 16'd20000;
    localparam logic [7:0]  RELEASE_WAIT_RST = 8'd20;
    localparam logic [7:0]  SAMPLE_DELAY_RST = 8'd28;
    localparam logic [3:0]  BYTES_FRAME_RST  = 4'd5;

    // status codes
    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_RESP    = 2'd1;
    localparam logic [1:0] ST_NO_RESP = 2'd2;
    localparam logic [1:0] ST_FRAME   = 2'd3;

    typedef struct packed {
        logic [15:0] start_low;
        logic [7:0]  release_wait;
        logic [7:0]  sample_delay;
        logic [3:0]  bytes_frame;
    } t_cfg;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] byte_value;
        logic       byte_valid;
        logic       drive_low;
    } t_res;

endpackage

>>> design/swsr_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsr_core: bus read sequencer
// Holds the read state and works out one result per tick or start beat.
// ----------------------------------------------------------------------------
module swsr_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  swsr_pkg::t_cfg i_cfg,
    input  logic           i_beat,
    input  logic           i_kind,
    input  logic           i_level,
    output swsr_pkg::t_res o_res
);
    import swsr_pkg::*;

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_START_LOW = 3'd1;
    localparam logic [2:0] PH_REL_WAIT  = 3'd2;
    localparam logic [2:0] PH_RESP_LOW  = 3'd3;
    localparam logic [2:0] PH_RESP_HIGH = 3'd4;
    localparam logic [2:0] PH_BIT_RISE  = 3'd5;
    localparam logic [2:0] PH_BIT_DELAY = 3'd6;
    localparam logic [2:0] PH_BIT_FALL  = 3'd7;

    logic [2:0]  r_phase, n_phase;
    logic [15:0] r_tick,  n_tick;
    logic [2:0]  r_bit,   n_bit;
    logic [7:0]  r_shift, n_shift;
    logic [3:0]  r_byte,  n_byte;

    logic [15:0] tick_inc;
    logic        do_sample;
    logic        do_done;
    t_res        res;

    assign tick_inc = r_tick + 16'd1;

    always_comb begin
        n_phase   = r_phase;
        n_tick    = r_tick;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_byte    = r_byte;
        do_sample = 1'b0;
        do_done   = 1'b0;
        res       = '0;

        if (i_kind) begin
            n_phase = PH_START_LOW;
            n_tick  = '0;
            n_bit   = '0;
            n_shift = '0;
            n_byte  = '0;
        end else begin
            case (r_phase)
                PH_START_LOW: begin
                    n_tick = tick_inc;
                    // a zero limit acts as one; a wrapped count also ends it
                    if (tick_inc >= i_cfg.start_low || tick_inc == 16'd0) begin
                        n_phase = PH_REL_WAIT;
                        n_tick  = '0;
                    end
                end
                PH_REL_WAIT: begin
                    if (r_tick >= {8'd0, i_cfg.release_wait}) begin
                        n_tick = '0;
                        if (i_level) begin
                            n_phase    = PH_IDLE;
                            res.status = ST_NO_RESP;
                        end else begin
                            n_phase = PH_RESP_LOW;
                        end
                    end else begin
                        n_tick = tick_inc;
                    end
                end
                PH_RESP_LOW: begin
                    if (i_level) n_phase = PH_RESP_HIGH;
                end
                PH_RESP_HIGH: begin
                    if (!i_level) begin
                        res.status = ST_RESP;
                        n_phase    = PH_BIT_RISE;
                        n_bit      = '0;
                        n_shift    = '0;
                        n_byte     = '0;
                    end
                end
                PH_BIT_RISE: begin
                    if (i_level) begin
                        n_tick = '0;
                        if (i_cfg.sample_delay == 8'd0) do_sample = 1'b1;
                        else                            n_phase   = PH_BIT_DELAY;
                    end
                end
                PH_BIT_DELAY: begin
                    n_tick = tick_inc;
                    if (tick_inc >= {8'd0, i_cfg.sample_delay}) begin
                        n_tick    = '0;
                        do_sample = 1'b1;
                    end
                end
                PH_BIT_FALL: begin
                    if (!i_level) do_done = 1'b1;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        if (do_sample) begin
            n_shift = {r_shift[6:0], i_level};
            if (i_level) n_phase = PH_BIT_FALL;
            else         do_done = 1'b1;
        end

        if (do_done) begin
            n_bit   = r_bit + 3'd1;
            n_phase = PH_BIT_RISE;
            if (n_bit == 3'd0) begin
                res.byte_valid = 1'b1;
                res.byte_value = n_shift;
                n_byte         = r_byte + 4'd1;
                if (n_byte >= i_cfg.bytes_frame) begin
                    res.status = ST_FRAME;
                    n_phase    = PH_IDLE;
                end
            end
        end

        res.drive_low = (n_phase == PH_START_LOW);
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_bit   <= '0;
            r_shift <= '0;
            r_byte  <= '0;
        end else if (i_beat) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_byte  <= n_byte;
        end
    end

endmodule

>>> design/single_wire_sensor_receiver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_wire_sensor_receiver_top: single-wire sensor bus master
// Drives the start pulse, checks the sensor response and shifts in the
// data bytes MSB first, one tick beat at a time.
// ----------------------------------------------------------------------------
//  channel   dir  handshake               payload
//  s_axis    in   s_axis_tvalid/tready    tuser: kind, tdata: line_level
//  m_axis    out  m_axis_tvalid/tready    tdata: drive_low, byte_valid,
//                                                byte_value, status
//  cfg       in   i_cfg_we (no wait)      i_cfg_idx, i_cfg_wdata
//
//  Every input beat yields one output beat in the next cycle; one beat per
//  clock is sustained while m_axis is ready. The sequencer state update
//  is a single combinational pass feeding the state and output registers.
//  Reset (synchronous, active low) returns to idle and loads default config.
//  A stall on m_axis holds the output register; s_axis_tready drops only
//  while that register is full and not being taken.
// ----------------------------------------------------------------------------
module single_wire_sensor_receiver_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config write port
    input  logic                          i_cfg_we,
    input  logic [swsr_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [swsr_pkg::CfgDataW-1:0] i_cfg_wdata,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [0] line_level, rest zero
    input  logic [0:0]                    s_axis_tuser,  // [0] kind (1 = start request)
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata   // [0] drive_low, [1] byte_valid,
                                                         // [9:2] byte_value, [11:10] status
);
    import swsr_pkg::*;

    t_cfg  r_cfg;
    logic  beat;
    t_res  res;
    logic  r_m_valid;
    t_res  r_m_res;

    // config registers; the user must write only while idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_low    <= START_LOW_RST;
            r_cfg.release_wait <= RELEASE_WAIT_RST;
            r_cfg.sample_delay <= SAMPLE_DELAY_RST;
            r_cfg.bytes_frame  <= BYTES_FRAME_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_START_LOW:    r_cfg.start_low    <= i_cfg_wdata;
                REG_RELEASE_WAIT: r_cfg.release_wait <= i_cfg_wdata[7:0];
                REG_SAMPLE_DELAY: r_cfg.sample_delay <= i_cfg_wdata[7:0];
                REG_BYTES_FRAME:  r_cfg.bytes_frame  <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // take a new beat whenever the output slot frees up this cycle
    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign beat          = s_axis_tvalid && s_axis_tready;

    swsr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_beat  (beat),
        .i_kind  (s_axis_tuser[0]),
        .i_level (s_axis_tdata[0]),
        .o_res   (res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (beat) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (beat) r_m_res <= res;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {4'd0, r_m_res};

    // every accepted beat shows up as a result on the next cycle
    a_beat_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        beat |=> m_axis_tvalid)
        else $error("accepted beat produced no result");

    // frame complete always carries its last byte
    a_frame_has_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_m_res.status == ST_FRAME) |-> r_m_res.byte_valid)
        else $error("frame complete without a byte");

    // no byte and no status while the start pulse is driven
    a_drive_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_m_res.drive_low)
            |-> (!r_m_res.byte_valid && r_m_res.status == ST_NONE))
        else $error("activity reported during start pulse");

    // byte value is zero unless a byte is presented
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !r_m_res.byte_valid) |-> (r_m_res.byte_value == 8'd0))
        else $error("stray byte value");

endmodule
